// File: rtl/gdr_pkg.sv
// Shared types and constants for the grid DDA ray caster.
// Used by the divider, the map memory and the top level; depends on nothing.
package gdr_pkg;

  // Map geometry: a square map of 4-bit cell codes, row-major address {row, col}.
  localparam int MAP_BITS  = 6;
  localparam int MAP_CELLS = 4096;
  localparam int ADDR_W    = 2 * MAP_BITS;
  localparam int CODE_W    = 4;

  // Screen and texture geometry.
  localparam logic [8:0]  SCREEN_LAST = 9'd479;
  localparam logic [23:0] HALF_H      = 24'd240;
  localparam logic [39:0] H_Q16       = 40'd31457280;
  localparam int          TEX_BITS    = 6;

  // Cell codes with a special meaning.
  localparam logic [CODE_W-1:0] EMPTY_CODE = 4'd0;
  localparam logic [CODE_W-1:0] DOOR_CODE  = 4'd2;
  localparam logic [CODE_W-1:0] ANIM_CODE  = 4'd3;

  // Fixed-point constants.
  localparam logic [23:0] SAT24    = 24'hFFFFFF;
  localparam logic [39:0] ONE_Q32  = 40'h01_0000_0000;
  localparam logic [7:0]  MAX_STEPS = 8'd130;

  // Divider widths.
  localparam int DIV_W = 40;
  localparam int DVS_W = 24;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_POS_X  = 3'd0;
  localparam logic [2:0] REG_POS_Y  = 3'd1;
  localparam logic [2:0] REG_DIR_X  = 3'd2;
  localparam logic [2:0] REG_DIR_Y  = 3'd3;
  localparam logic [2:0] REG_PLN_X  = 3'd4;
  localparam logic [2:0] REG_PLN_Y  = 3'd5;
  localparam logic [2:0] REG_DOORS  = 3'd6;
  localparam logic [2:0] REG_ANIM   = 3'd7;

  // Texture kinds.
  localparam logic [2:0] KIND_DOOR  = 3'd0;
  localparam logic [2:0] KIND_ANIM  = 3'd1;
  localparam logic [2:0] KIND_WEST  = 3'd2;
  localparam logic [2:0] KIND_EAST  = 3'd3;
  localparam logic [2:0] KIND_SOUTH = 3'd4;
  localparam logic [2:0] KIND_NORTH = 3'd5;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // Saturate a quotient to 24 bits.
  function automatic logic [23:0] sat24(input logic [DIV_W-1:0] q);
    sat24 = (|q[DIV_W-1:24]) ? SAT24 : q[23:0];
  endfunction

endpackage

// File: rtl/gdr_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on gdr_pkg for widths and the request struct.
module gdr_div import gdr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic             busy;
  logic [DVS_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [5:0]       cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: the dividend shifts out while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
      cnt <= cnt + 6'd1;
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/gdr_grid_mem.sv
// Map memory: one write port, one read port with registered read data.
// Depends on gdr_pkg for the map size and code width.
module gdr_grid_mem import gdr_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CODE_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CODE_W-1:0] rdata
);

  logic [CODE_W-1:0] mem [MAP_CELLS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/grid_dda_ray_caster_unit.sv
// Grid DDA ray caster: holds a 64x64 map of cell codes and casts one ray per cast item.
// Depends on gdr_pkg, gdr_div and gdr_grid_mem.
//
// After reset the block clears the map, one cell a cycle, with s_tready low;
// configuration writes are taken throughout. A write item is taken in S_IDLE and
// passes through S_DONE. A cast item is sequenced through the states, with up to
// four passes of the shared divider (two reciprocals, the wall distance and the line
// height; a pass is skipped for a zero divisor), and each cell stepped waits on the
// map read, issued in S_STEP and used in S_TEST. One item is worked on at a time;
// the next is accepted while a finished result waits on m_tvalid.
module grid_dda_ray_caster_unit import gdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: cell_col[5:0], cell_row[11:6], cell_code[15:12], camera_offset[33:16]
  input  logic [39:0] s_tdata,
  // s_tuser: func[0]
  input  logic [0:0]  s_tuser,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: hit_found[0], wall_dist[24:1], hit_side[25], span_start[34:26],
  // span_end[43:35], tex_column[49:44], tex_kind[52:50], anim_frame[57:53]
  output logic [63:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_RAY   = 13'b0000000000100,
    S_DIVX  = 13'b0000000001000,
    S_DIVY  = 13'b0000000010000,
    S_INIT  = 13'b0000000100000,
    S_STEP  = 13'b0000001000000,
    S_TEST  = 13'b0000010000000,
    S_DIVW  = 13'b0000100000000,
    S_DIVL  = 13'b0001000000000,
    S_TEXM  = 13'b0010000000000,
    S_FIN   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  // Configuration registers.
  logic [23:0]        pos_x, pos_y;
  logic signed [17:0] dir_x, dir_y, pln_x, pln_y;
  logic               doors_closed;
  logic [7:0]         anim_clock;

  state_t             state;
  logic [ADDR_W-1:0]  clr_addr;
  logic               div_issued;

  // Per-ray working registers.
  logic signed [17:0] cam;
  logic signed [19:0] rx, ry;
  logic [23:0]        dx, dy;
  logic [33:0]        sdx, sdy;
  logic signed [7:0]  cx, cy;
  logic               side;
  logic [CODE_W-1:0]  code;
  logic [7:0]         step_cnt;
  logic [23:0]        wd;
  logic [8:0]         span_s, span_e;
  logic signed [44:0] tex_prod;
  logic [57:0]        res;

  // Memory and divider connections.
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [CODE_W-1:0]  mem_wdata, mem_rdata;
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;

  // Combinational helpers.
  logic               cfg_we, in_fire, is_cast;
  logic signed [35:0] prod_x, prod_y;
  logic [19:0]        abs_rx, abs_ry, abs_ray;
  logic signed [19:0] ray_sel;
  logic [16:0]        frac_x, frac_y;
  logic [40:0]        init_x, init_y;
  logic               step_x;
  logic signed [7:0]  nx, ny;
  logic               next_out;
  logic               hit;
  logic [5:0]         hit_cell;
  logic [23:0]        cell_pos;
  logic [25:0]        num;
  logic [23:0]        abs_num;
  logic [23:0]        half;
  logic [24:0]        half_sum;
  logic [15:0]        frac_hit;
  logic [TEX_BITS-1:0] tex;
  logic [2:0]         kind;
  logic [15:0]        anim_mul;
  logic [4:0]         anim_frame;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready;
  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign is_cast  = s_tuser[0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= '0;
      pos_y        <= '0;
      dir_x        <= 18'sd65536;
      dir_y        <= '0;
      pln_x        <= '0;
      pln_y        <= 18'sd43254;
      doors_closed <= 1'b1;
      anim_clock   <= '0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_POS_X: pos_x        <= pwdata[23:0];
        REG_POS_Y: pos_y        <= pwdata[23:0];
        REG_DIR_X: dir_x        <= pwdata[17:0];
        REG_DIR_Y: dir_y        <= pwdata[17:0];
        REG_PLN_X: pln_x        <= pwdata[17:0];
        REG_PLN_Y: pln_y        <= pwdata[17:0];
        REG_DOORS: doors_closed <= pwdata[0];
        REG_ANIM:  anim_clock   <= pwdata[7:0];
        default:   ;
      endcase
    end
  end

  // Configuration reads.
  always_comb begin
    case (paddr[4:2])
      REG_POS_X: prdata = 32'(pos_x);
      REG_POS_Y: prdata = 32'(pos_y);
      REG_DIR_X: prdata = 32'(unsigned'(dir_x));
      REG_DIR_Y: prdata = 32'(unsigned'(dir_y));
      REG_PLN_X: prdata = 32'(unsigned'(pln_x));
      REG_PLN_Y: prdata = 32'(unsigned'(pln_y));
      REG_DOORS: prdata = 32'(doors_closed);
      REG_ANIM:  prdata = 32'(anim_clock);
      default:   prdata = '0;
    endcase
  end

  // Ray direction and magnitudes.
  always_comb begin
    prod_x  = pln_x * cam;
    prod_y  = pln_y * cam;
    abs_rx  = rx[19] ? 20'(-rx) : 20'(rx);
    abs_ry  = ry[19] ? 20'(-ry) : 20'(ry);
    ray_sel = side ? ry : rx;
    abs_ray = side ? abs_ry : abs_rx;
  end

  // Initial side distances.
  always_comb begin
    frac_x = rx[19] ? {1'b0, pos_x[15:0]} : 17'h10000 - {1'b0, pos_x[15:0]};
    frac_y = ry[19] ? {1'b0, pos_y[15:0]} : 17'h10000 - {1'b0, pos_y[15:0]};
    init_x = 41'(frac_x) * 41'(dx);
    init_y = 41'(frac_y) * 41'(dy);
  end

  // One DDA step: ties step in y.
  always_comb begin
    step_x   = sdx < sdy;
    nx       = rx[19] ? cx - 8'sd1 : cx + 8'sd1;
    ny       = ry[19] ? cy - 8'sd1 : cy + 8'sd1;
    next_out = step_x ? (nx[7] || nx[6]) : (ny[7] || ny[6]);
    hit      = (mem_rdata == DOOR_CODE) ? !doors_closed : (mem_rdata != EMPTY_CODE);
  end

  // Distance numerator from the hit face to the player.
  always_comb begin
    hit_cell = side ? cy[5:0] : cx[5:0];
    cell_pos = side ? pos_y : pos_x;
    num      = {4'b0, hit_cell, 16'h0} + ((side ? ry[19] : rx[19]) ? 26'h10000 : 26'h0)
             - {2'b0, cell_pos};
    abs_num  = num[25] ? 24'(-num) : num[23:0];
  end

  // Span from the line height quotient.
  always_comb begin
    half     = div_q[24:1];
    half_sum = {1'b0, half} + {1'b0, HALF_H};
  end

  // Texture column, kind and animation frame.
  always_comb begin
    frac_hit = (side ? pos_x[15:0] : pos_y[15:0]) + tex_prod[31:16];
    tex      = frac_hit[15 -: TEX_BITS];
    if ((!side && !rx[19] && rx != 20'sd0) || (side && ry[19])) begin
      tex = ~tex;
    end
    if (code == DOOR_CODE) begin
      kind = KIND_DOOR;
    end else if (code == ANIM_CODE) begin
      kind = KIND_ANIM;
    end else if (!side) begin
      kind = (pos_x > {cx[5:0], 16'h0}) ? KIND_WEST : KIND_EAST;
    end else begin
      kind = (pos_y > {cy[5:0], 16'h0}) ? KIND_SOUTH : KIND_NORTH;
    end
    anim_mul   = 16'(anim_clock) * 16'd205;
    anim_frame = (kind == KIND_ANIM) ? anim_mul[15:11] : 5'd0;
  end

  // Divider requests for the four divisions of a cast.
  always_comb begin
    div_req = '0;
    case (state)
      S_DIVX: begin
        div_req.start    = !div_issued && rx != 20'sd0;
        div_req.dividend = ONE_Q32;
        div_req.divisor  = 24'(abs_rx);
      end
      S_DIVY: begin
        div_req.start    = !div_issued && ry != 20'sd0;
        div_req.dividend = ONE_Q32;
        div_req.divisor  = 24'(abs_ry);
      end
      S_DIVW: begin
        div_req.start    = !div_issued && ray_sel != 20'sd0;
        div_req.dividend = {abs_num, 16'h0};
        div_req.divisor  = 24'(abs_ray);
      end
      S_DIVL: begin
        div_req.start    = !div_issued && wd != 24'd0;
        div_req.dividend = H_Q16;
        div_req.divisor  = wd;
      end
      default: ;
    endcase
  end

  // Map memory ports: clearing pass, write items and the DDA reads.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {s_tdata[11:6], s_tdata[5:0]};
    mem_wdata = s_tdata[15:12];
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = EMPTY_CODE;
    end else if (in_fire && !is_cast) begin
      mem_we = 1'b1;
    end
    mem_raddr = step_x ? {cy[5:0], nx[5:0]} : {ny[5:0], cx[5:0]};
  end

  gdr_grid_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      div_issued <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // A new result is offered once the previous one has been taken.
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (div_req.start) begin
        div_issued <= 1'b1;
      end else if (div_done) begin
        div_issued <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state <= is_cast ? S_RAY : S_DONE;
          end
        end
        S_RAY:  state <= S_DIVX;
        S_DIVX: begin
          if (!div_issued && rx == 20'sd0) begin
            state <= S_DIVY;
          end else if (div_done) begin
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if ((!div_issued && ry == 20'sd0) || div_done) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          state <= (|pos_x[23:22] || |pos_y[23:22]) ? S_DONE : S_STEP;
        end
        S_STEP: state <= next_out ? S_DONE : S_TEST;
        S_TEST: begin
          if (hit) begin
            state <= S_DIVW;
          end else if (step_cnt == MAX_STEPS) begin
            state <= S_DONE;
          end else begin
            state <= S_STEP;
          end
        end
        S_DIVW: begin
          if ((!div_issued && ray_sel == 20'sd0) || div_done) begin
            state <= S_DIVL;
          end
        end
        S_DIVL: begin
          if ((!div_issued && wd == 24'd0) || div_done) begin
            state <= S_TEXM;
          end
        end
        S_TEXM: state <= S_FIN;
        S_FIN:  state <= S_DONE;
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the cast.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cam <= s_tdata[33:16];
        res <= '0;
      end
      S_RAY: begin
        rx <= 20'(dir_x) + 20'(prod_x >>> 16);
        ry <= 20'(dir_y) + 20'(prod_y >>> 16);
      end
      S_DIVX: begin
        if (!div_issued && rx == 20'sd0) begin
          dx <= SAT24;
        end else if (div_done) begin
          dx <= sat24(div_q);
        end
      end
      S_DIVY: begin
        if (!div_issued && ry == 20'sd0) begin
          dy <= SAT24;
        end else if (div_done) begin
          dy <= sat24(div_q);
        end
      end
      S_INIT: begin
        sdx      <= 34'(init_x >> 16);
        sdy      <= 34'(init_y >> 16);
        cx       <= {2'b00, pos_x[21:16]};
        cy       <= {2'b00, pos_y[21:16]};
        step_cnt <= '0;
      end
      S_STEP: begin
        step_cnt <= step_cnt + 8'd1;
        if (step_x) begin
          sdx  <= sdx + 34'(dx);
          cx   <= nx;
          side <= 1'b0;
        end else begin
          sdy  <= sdy + 34'(dy);
          cy   <= ny;
          side <= 1'b1;
        end
      end
      S_TEST: code <= mem_rdata;
      S_DIVW: begin
        if (!div_issued && ray_sel == 20'sd0) begin
          wd <= SAT24;
        end else if (div_done) begin
          wd <= sat24(div_q);
        end
      end
      S_DIVL: begin
        if (!div_issued && wd == 24'd0) begin
          span_s <= '0;
          span_e <= SCREEN_LAST;
        end else if (div_done) begin
          span_s <= (half >= HALF_H) ? 9'd0 : 9'(HALF_H - half);
          span_e <= (half_sum > 25'(SCREEN_LAST)) ? SCREEN_LAST : half_sum[8:0];
        end
      end
      S_TEXM: tex_prod <= $signed({1'b0, wd}) * (side ? rx : ry);
      S_FIN:  res <= {anim_frame, kind, tex, span_e, span_s, side, wd, 1'b1};
      default: ;
    endcase
  end

  // Output payload loads when the result is handed over.
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {6'b0, res};
    end
  end

endmodule

// File: sim/grid_dda_ray_caster_unit_tb.sv
// Self-checking testbench for the grid DDA ray caster: map writes and ray casts
// against an in-bench fixed-point predictor. Depends on gdr_pkg and the RTL top level.
`timescale 1ns / 100ps

module grid_dda_ray_caster_unit_tb;
  import gdr_pkg::*;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;
  localparam int   IDLE_LIMIT = 20000;
  localparam int   ITEM_GOAL  = 1500;
  localparam longint Q16_ONE  = 65536;
  localparam longint SAT_DIST = 24'hFFFFFF;

  typedef struct {
    logic        func;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [3:0]  code;
    logic [17:0] cam;
  } map_item_t;

  typedef struct {
    logic        hit;
    logic [23:0] wall_dist;
    logic        side;
    logic [8:0]  span_lo;
    logic [8:0]  span_hi;
    logic [5:0]  tex;
    logic [2:0]  kind;
    logic [4:0]  frame;
  } ray_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  grid_dda_ray_caster_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Shadow copy of the block's registers and map.
  logic [23:0]        pos_x = 24'd0;
  logic [23:0]        pos_y = 24'd0;
  logic signed [17:0] dir_x = 18'sd65536;
  logic signed [17:0] dir_y = 18'sd0;
  logic signed [17:0] plane_x = 18'sd0;
  logic signed [17:0] plane_y = 18'sd43254;
  logic               doors_pass = 1'b1;
  logic [7:0]         anim_clock = 8'd0;
  logic [3:0]         grid_model [MAP_CELLS];

  map_item_t   pending_items [$];
  ray_result_t awaited_results [$];
  map_item_t   held_item;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          hold_cnt = 0;
  bit          hold_done = 0;
  int          items_in = 0;
  int          idle_cycles = 0;
  bit          failed = 0;

  initial begin
    for (int i = 0; i < MAP_CELLS; i++) grid_model[i] = EMPTY_CODE;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint recip_q16(longint r);
    longint m, d;
    m = (r < 0) ? -r : r;
    if (m == 0) return SAT_DIST;
    d = (64'sd1 <<< 32) / m;
    return (d > SAT_DIST) ? SAT_DIST : d;
  endfunction

  // Fixed-point DDA walk for one cast, using the shadow registers and map.
  function automatic ray_result_t trace_ray(logic [17:0] cam_raw);
    ray_result_t res;
    longint px, py, rx, ry, cam, cx, cy, sx, sy, num, ray, wx;
    longint dx, dy, sdx, sdy, wd, lh, half, s, e, tex, f;
    logic [3:0] code;
    int side, hit;
    res = '{default: '0};
    px = pos_x;
    py = pos_y;
    cam = longint'($signed(cam_raw));
    rx = longint'(dir_x) + ((longint'(plane_x) * cam) >>> 16);
    ry = longint'(dir_y) + ((longint'(plane_y) * cam) >>> 16);
    dx = recip_q16(rx);
    dy = recip_q16(ry);
    cx = px >>> 16;
    cy = py >>> 16;
    sx = (rx < 0) ? -1 : 1;
    sy = (ry < 0) ? -1 : 1;
    sdx = (((rx < 0) ? (px & 16'hFFFF) : (Q16_ONE - (px & 16'hFFFF))) * dx) >>> 16;
    sdy = (((ry < 0) ? (py & 16'hFFFF) : (Q16_ONE - (py & 16'hFFFF))) * dy) >>> 16;
    if (cx >= 64 || cy >= 64) return res;
    hit = 0;
    side = 0;
    code = EMPTY_CODE;
    for (int i = 0; i < 130 && hit == 0; i++) begin
      if (sdx < sdy) begin
        sdx += dx;
        cx += sx;
        side = 0;
      end else begin
        sdy += dy;
        cy += sy;
        side = 1;
      end
      if (cx < 0 || cy < 0 || cx >= 64 || cy >= 64) return res;
      code = grid_model[cy * 64 + cx];
      if (code == DOOR_CODE) hit = doors_pass ? 0 : 1;
      else if (code != EMPTY_CODE) hit = 1;
    end
    if (hit == 0) return res;

    if (side == 1) begin
      num = cy * Q16_ONE + ((sy < 0) ? Q16_ONE : 0) - py;
      ray = ry;
    end else begin
      num = cx * Q16_ONE + ((sx < 0) ? Q16_ONE : 0) - px;
      ray = rx;
    end
    if (ray == 0) begin
      wd = SAT_DIST;
    end else begin
      wd = (((num < 0) ? -num : num) <<< 16) / ((ray < 0) ? -ray : ray);
      if (wd > SAT_DIST) wd = SAT_DIST;
    end

    // A zero distance means an unbounded line height, so the span covers the screen.
    lh = (wd == 0) ? 64'hFFFF_FFFF : ((longint'(480) <<< 16) / wd);
    half = lh / 2;
    s = (half >= 240) ? 0 : 240 - half;
    e = half + 240;
    if (e > 479) e = 479;

    wx = (side == 1) ? px + ((wd * rx) >>> 16) : py + ((wd * ry) >>> 16);
    f = wx & 16'hFFFF;
    tex = (f * 64) >>> 16;
    if ((side == 0 && rx > 0) || (side == 1 && ry < 0)) tex = 63 - tex;

    res.hit = 1'b1;
    res.wall_dist = wd[23:0];
    res.side = side[0];
    res.span_lo = s[8:0];
    res.span_hi = e[8:0];
    res.tex = tex[5:0];
    if (code == DOOR_CODE) res.kind = KIND_DOOR;
    else if (code == ANIM_CODE) res.kind = KIND_ANIM;
    else if (side == 0) res.kind = (px > cx * Q16_ONE) ? KIND_WEST : KIND_EAST;
    else res.kind = (py > cy * Q16_ONE) ? KIND_SOUTH : KIND_NORTH;
    res.frame = (res.kind == KIND_ANIM) ? 5'(anim_clock / 10) : 5'd0;
    return res;
  endfunction

  // Input side: present queued items with random gaps and record what each should yield.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        items_in++;
        if (held_item.func == FUNC_CAST) begin
          awaited_results.push_back(trace_ray(held_item.cam));
        end else begin
          grid_model[{held_item.row, held_item.col}] = held_item.code;
          awaited_results.push_back('{default: '0});
        end
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          held_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= held_item.func;
          s_tdata <= {6'd0, held_item.cam, held_item.code, held_item.row, held_item.col};
          tx_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else if (!hold_done && items_in >= 300) begin
      hold_done = 1;
      hold_cnt = 3000;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_gap = pick_gap();
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failed = 1;
    end
  endfunction

  // Compare every result transfer with the oldest outstanding prediction.
  always @(posedge clk) begin
    ray_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with no prediction outstanding: %h", m_tdata);
        failed = 1;
      end else begin
        want = awaited_results.pop_front();
        check_field("hit_found", want.hit, m_tdata[0]);
        check_field("wall_dist", want.wall_dist, m_tdata[24:1]);
        check_field("hit_side", want.side, m_tdata[25]);
        check_field("span_start", want.span_lo, m_tdata[34:26]);
        check_field("span_end", want.span_hi, m_tdata[43:35]);
        check_field("tex_column", want.tex, m_tdata[49:44]);
        check_field("tex_kind", want.kind, m_tdata[52:50]);
        check_field("anim_frame", want.frame, m_tdata[57:53]);
      end
    end
  end

  // Watchdog on cycles with no transfer on either stream.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POS_X: pos_x = val[23:0];
      REG_POS_Y: pos_y = val[23:0];
      REG_DIR_X: dir_x = val[17:0];
      REG_DIR_Y: dir_y = val[17:0];
      REG_PLN_X: plane_x = val[17:0];
      REG_PLN_Y: plane_y = val[17:0];
      REG_DOORS: doors_pass = val[0];
      default:   anim_clock = val[7:0];
    endcase
  endtask

  task automatic set_view(logic [23:0] px, logic [23:0] py, logic [17:0] dx, logic [17:0] dy,
                          logic [17:0] plx, logic [17:0] ply, logic doors, logic [7:0] anim);
    reg_write(REG_POS_X, px);
    reg_write(REG_POS_Y, py);
    reg_write(REG_DIR_X, {{14{dx[17]}}, dx});
    reg_write(REG_DIR_Y, {{14{dy[17]}}, dy});
    reg_write(REG_PLN_X, {{14{plx[17]}}, plx});
    reg_write(REG_PLN_Y, {{14{ply[17]}}, ply});
    reg_write(REG_DOORS, doors);
    reg_write(REG_ANIM, anim);
  endtask

  task automatic push_write(int col, int row, int code);
    pending_items.push_back('{FUNC_WRITE, 6'(col), 6'(row), 4'(code), 18'($urandom)});
  endtask

  task automatic push_cast(int cam);
    pending_items.push_back('{FUNC_CAST, 6'($urandom), 6'($urandom), 4'($urandom), 18'(cam)});
  endtask

  // Wait until the block has drained, then leave a short margin.
  task automatic drain();
    @(posedge clk);
    while (pending_items.size() > 0 || s_tvalid || awaited_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int rand_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return EMPTY_CODE;
    if (r < 50) return DOOR_CODE;
    if (r < 65) return ANIM_CODE;
    return $urandom_range(1, 15);
  endfunction

  function automatic int rand_cam();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -65536;
    if (r == 1) return 65536;
    if (r == 2) return 0;
    return $urandom_range(0, 131072) - 65536;
  endfunction

  function automatic logic [17:0] rand_vec(int phase);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return (phase % 2) ? 18'h1FFFF : 18'h20000;
    if (r == 1) return 18'd0;
    return 18'($urandom);
  endfunction

  initial begin
    int phase;
    int pcx, pcy, frac;
    logic [23:0] px, py;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset view: player in the corner cell looking along +x.
    push_cast(0);
    push_write(63, 63, 15);
    push_write(0, 63, 1);
    push_write(4, 0, DOOR_CODE);
    push_cast(0);
    push_write(6, 0, ANIM_CODE);
    push_cast(0);
    push_cast(-65536);
    push_cast(65536);
    drain();
    // Doors now stop rays; animated frame at the top of the clock range.
    set_view(24'h00_8000, 24'h00_0000, 18'sd65536, 18'sd0, 18'sd0, 18'sd43254, 1'b0, 8'd255);
    push_cast(0);
    push_write(4, 0, EMPTY_CODE);
    push_cast(0);
    push_cast(1);
    drain();
    // Player on a cell edge facing -x into an adjacent wall gives zero distance.
    set_view(24'h05_0000, 24'h00_8000, -18'sd65536, 18'sd0, 18'sd0, 18'sd0, 1'b1, 8'd37);
    push_write(4, 0, 9);
    push_cast(0);
    push_cast(-65536);
    drain();
    // Axis-aligned ray along y with a zero x component, and a start outside the map.
    set_view(24'h00_4000, 24'h00_0000, 18'sd0, 18'sd131071, 18'sd0, 18'sd0, 1'b1, 8'd0);
    push_cast(0);
    drain();
    set_view(24'hFF_FFFF, 24'hFF_FFFF, -18'sd131072, -18'sd131072, 18'sd131071,
             -18'sd131072, 1'b0, 8'd100);
    push_cast(65536);
    push_cast(-65536);
    drain();

    // Random phases: a fresh view, a local map neighborhood, then a mix of writes and casts.
    phase = 0;
    while (items_in < ITEM_GOAL) begin
      pcx = $urandom_range(0, 63);
      pcy = $urandom_range(0, 63);
      frac = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 65535);
      px = 24'((pcx << 16) | frac);
      py = 24'((pcy << 16) | (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 65535)));
      if ($urandom_range(0, 19) == 0) px = 24'($urandom);
      set_view(px, py, rand_vec(phase), rand_vec(phase + 1), rand_vec(phase),
               rand_vec(phase + 1), 1'($urandom), 8'($urandom));
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(0, 99) < 45) begin
          if ($urandom_range(0, 9) < 7)
            push_write((pcx + $urandom_range(0, 14) - 7) & 63,
                       (pcy + $urandom_range(0, 14) - 7) & 63, rand_code());
          else
            push_write($urandom_range(0, 63), $urandom_range(0, 63), rand_code());
        end else begin
          push_cast(rand_cam());
        end
      end
      drain();
      phase++;
    end

    drain();
    repeat (500) @(posedge clk);
    if (!failed && awaited_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
